@@ src/wsdf_pkg.sv @@
package wsdf_pkg;

  localparam int unsigned LengthBitsDef = 24;
  localparam int unsigned CfgWidth = 24;
  localparam logic [23:0] MaxPayloadRst = 24'd16384;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_e;

  typedef enum logic [2:0] {
    KIND_MSG        = 3'd0,
    KIND_PING       = 3'd1,
    KIND_MSG_END    = 3'd2,
    KIND_PING_EMPTY = 3'd3,
    KIND_CLOSED     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    WHY_PEER   = 2'd0,
    WHY_PROTO  = 2'd1,
    WHY_UNSUPP = 2'd2,
    WHY_LONG   = 2'd3
  } why_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [7:0] RsvMask = 8'h70;
  localparam logic [6:0] Len16 = 7'h7e;
  localparam logic [6:0] Len64 = 7'h7f;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       end_mark;
    logic [1:0] why;
  } result_t;

endpackage

@@ src/websocket_frame_deframer_top.sv @@
// Latency: a result is written into the result queue and appears on the output when it reaches the queue head.
// Throughput: one byte per cycle while the result queue is not full; the front parser
// runs every cycle, and the two-entry queue absorbs results while the output is stalled.
// Reset: asynchronous, active low; clears parser state, the close flag and the queue,
// and sets max_q to 16384.
module websocket_frame_deframer_top #(
  parameter int unsigned LENGTH_BITS = wsdf_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wsdf_pkg::CfgWidth-1:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  out_data_o,
  output logic        end_mark_o,
  output logic [1:0]  close_reason_o
);
  import wsdf_pkg::*;

  logic [CfgWidth-1:0] max_q;
  logic                in_fire, res_valid, q_full;
  result_t             res, head;

  assign cfg_ready_o = 1'b1;
  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxPayloadRst;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Hold input while a result could not be stored.
  assign in_ready_o = !q_full;

  wsdf_front #(.LengthBits(LENGTH_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .rx_byte_i,
    .max_payload_i(max_q),
    .res_valid_o(res_valid),
    .res_o(res)
  );

  wsdf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(res_valid),
    .push_data_i(res),
    .full_o(q_full),
    .valid_o(out_valid_o),
    .data_o(head),
    .pop_i(out_ready_i)
  );

  assign out_kind_o = head.kind;
  assign out_data_o = head.data;
  assign end_mark_o = head.end_mark;
  assign close_reason_o = head.why;

endmodule

@@ src/wsdf_front.sv @@
module wsdf_front #(
  parameter int unsigned LengthBits = wsdf_pkg::LengthBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_fire_i,
  input  logic [7:0]               rx_byte_i,
  input  logic [wsdf_pkg::CfgWidth-1:0] max_payload_i,
  output logic                     res_valid_o,
  output wsdf_pkg::result_t        res_o
);
  import wsdf_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   final_q, final_d;
  logic [3:0]             ext_left_q, ext_left_d;
  logic [LengthBits-1:0]  remain_q, remain_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             idx_q, idx_d;
  logic                   msg_open_q, msg_open_d;
  logic                   closed_q, closed_d;

  logic                   len_ovf;
  logic [LengthBits-1:0]  len_val;
  logic                   do_len;
  logic                   data_op;
  logic [LengthBits-1:0]  remain_dec;
  logic [7:0]             key_byte;
  logic                   too_big;

  assign data_op = (opcode_q == OP_CONT) || (opcode_q == OP_TEXT);
  assign remain_dec = remain_q - LengthBits'(1);

  always_comb begin
    unique case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    if (phase_q == PH_EXT) begin
      len_val = LengthBits'({remain_q, rx_byte_i});
      len_ovf = ovf_q || (remain_q[LengthBits-1:LengthBits-8] != 8'd0);
    end else begin
      len_val = LengthBits'(rx_byte_i[6:0]);
      len_ovf = 1'b0;
    end
  end

  always_comb begin
    if (LengthBits > CfgWidth) begin
      too_big = (len_val > LengthBits'(max_payload_i));
    end else begin
      too_big = (CfgWidth'(len_val) > max_payload_i);
    end
  end

  always_comb begin
    phase_d = phase_q;
    opcode_d = opcode_q;
    final_d = final_q;
    ext_left_d = ext_left_q;
    remain_d = remain_q;
    ovf_d = ovf_q;
    key_d = key_q;
    idx_d = idx_q;
    msg_open_d = msg_open_q;
    closed_d = closed_q;
    res_valid_o = 1'b0;
    res_o = '0;
    do_len = 1'b0;
    if (in_fire_i && !closed_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          if ((rx_byte_i & RsvMask) != 8'd0) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_CLOSED;
            res_o.why = WHY_PROTO;
          end else begin
            final_d = rx_byte_i[7];
            opcode_d = rx_byte_i[3:0];
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          res_o.kind = KIND_CLOSED;
          if (!rx_byte_i[7]) begin
            res_valid_o = 1'b1;
            res_o.why = WHY_PROTO;
          end else if (opcode_q == OP_CLOSE) begin
            res_valid_o = 1'b1;
            res_o.why = WHY_PEER;
          end else if (opcode_q == OP_BIN) begin
            res_valid_o = 1'b1;
            res_o.why = WHY_UNSUPP;
          end else if (((opcode_q == OP_PING) || (opcode_q == OP_PONG)) && !final_q) begin
            res_valid_o = 1'b1;
            res_o.why = WHY_PROTO;
          end else if (!data_op && opcode_q != OP_PING && opcode_q != OP_PONG) begin
            res_valid_o = 1'b1;
            res_o.why = WHY_PROTO;
          end else begin
            ovf_d = 1'b0;
            remain_d = '0;
            if (rx_byte_i[6:0] == Len64) begin
              ext_left_d = 4'd8;
              phase_d = PH_EXT;
            end else if (rx_byte_i[6:0] == Len16) begin
              ext_left_d = 4'd2;
              phase_d = PH_EXT;
            end else begin
              do_len = 1'b1;
            end
          end
        end
        PH_EXT: begin
          ovf_d = len_ovf;
          remain_d = len_val;
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) do_len = 1'b1;
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            if (remain_q == '0) begin
              phase_d = PH_HDR0;
              if (data_op) begin
                msg_open_d = !final_q;
                if (final_q) begin
                  res_valid_o = 1'b1;
                  res_o.kind = KIND_MSG_END;
                  res_o.end_mark = 1'b1;
                end
              end else if (opcode_q == OP_PING) begin
                res_valid_o = 1'b1;
                res_o.kind = KIND_PING_EMPTY;
                res_o.end_mark = 1'b1;
              end
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          idx_d = idx_q + 2'd1;
          remain_d = remain_dec;
          res_o.data = rx_byte_i ^ key_byte;
          if (remain_dec == '0) begin
            phase_d = PH_HDR0;
            if (data_op) msg_open_d = !final_q;
          end
          if (data_op) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_MSG;
            res_o.end_mark = (remain_dec == '0) && final_q;
          end else if (opcode_q == OP_PING) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_PING;
            res_o.end_mark = (remain_dec == '0);
          end else begin
            res_o.data = '0;
          end
        end
        default: phase_d = PH_HDR0;
      endcase
      if (do_len) begin
        remain_d = len_val;
        if (len_ovf || too_big) begin
          res_valid_o = 1'b1;
          res_o = '0;
          res_o.kind = KIND_CLOSED;
          res_o.why = WHY_LONG;
        end else begin
          key_d = '0;
          idx_d = '0;
          phase_d = PH_MASK;
        end
      end
      if (res_valid_o && res_o.kind == KIND_CLOSED) closed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      opcode_q <= '0;
      final_q <= 1'b0;
      ext_left_q <= '0;
      remain_q <= '0;
      ovf_q <= 1'b0;
      key_q <= '0;
      idx_q <= '0;
      msg_open_q <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      opcode_q <= opcode_d;
      final_q <= final_d;
      ext_left_q <= ext_left_d;
      remain_q <= remain_d;
      ovf_q <= ovf_d;
      key_q <= key_d;
      idx_q <= idx_d;
      msg_open_q <= msg_open_d;
      closed_q <= closed_d;
    end
  end

  closed_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q) else $error("closed flag dropped");
  no_res_closed_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> !res_valid_o) else $error("result after close");
  data_idx_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && !closed_q && phase_q == PH_MASK && idx_q == 2'd3 && remain_q != '0)
    |=> (phase_q == PH_DATA && idx_q == 2'd0)) else $error("mask index misaligned");

endmodule

@@ src/wsdf_queue.sv @@
module wsdf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wsdf_pkg::result_t    push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output wsdf_pkg::result_t    data_o,
  input  logic                 pop_i
);
  import wsdf_pkg::*;

  result_t    mem_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop, do_push;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'(QueueDepth));
  assign data_o = mem_q[rd_q];
  assign do_pop = pop_i && valid_o;
  assign do_push = push_i && !full_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  no_overflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth)) else $error("queue count out of range");
  stall_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i && !push_i) |=> (valid_o && $stable(data_o)))
    else $error("head lost while stalled");

endmodule
